// File: sv/alu_with_status_flags_macros.svh
// assertion helpers shared by the rtl
`ifndef ALU_WITH_STATUS_FLAGS_MACROS_SVH
`define ALU_WITH_STATUS_FLAGS_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AWSF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define AWSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/awsf_pkg.sv
package awsf_pkg;

  localparam int OpW = 4;
  localparam int DataW = 16;

  localparam logic [OpW-1:0] OP_MOV  = 4'd0;
  localparam logic [OpW-1:0] OP_ADD  = 4'd1;
  localparam logic [OpW-1:0] OP_ADDC = 4'd2;
  localparam logic [OpW-1:0] OP_SUB  = 4'd3;
  localparam logic [OpW-1:0] OP_SUBC = 4'd4;
  localparam logic [OpW-1:0] OP_CMP  = 4'd5;
  localparam logic [OpW-1:0] OP_DADD = 4'd6;
  localparam logic [OpW-1:0] OP_BIT  = 4'd7;
  localparam logic [OpW-1:0] OP_BIC  = 4'd8;
  localparam logic [OpW-1:0] OP_BIS  = 4'd9;
  localparam logic [OpW-1:0] OP_XOR  = 4'd10;
  localparam logic [OpW-1:0] OP_AND  = 4'd11;
  localparam logic [OpW-1:0] OP_RRC  = 4'd12;
  localparam logic [OpW-1:0] OP_RRA  = 4'd13;
  localparam logic [OpW-1:0] OP_SWPB = 4'd14;
  localparam logic [OpW-1:0] OP_SXT  = 4'd15;

  localparam logic [DataW-1:0] ByteMask = 16'h00FF;
  localparam logic [DataW-1:0] HighByte = 16'hFF00;

  typedef struct packed {
    logic v;
    logic n;
    logic z;
    logic c;
  } flags_t;

endpackage

// File: sv/alu_with_status_flags.sv
// channel  | ports                        | word
// ---------+------------------------------+----------------------------------------
// input    | in_tvalid/in_tready/in_tdata | tdata: source, dest; tuser: op, byte
// result   | out_tvalid/out_tready/..     | tdata: result, c, z, n, v; tuser: wb
//
// one word per cycle while the result side is not stalled: an operand register,
// one pass through the alu logic, then a result register.
// the stored flags update as a word moves into the result register, so the
// next word in the operand register already sees its carry.
// synchronous active-low reset clears both valid bits and the flags.
// a stalled result holds the operand stage; input stalls only when both are full.
`include "alu_with_status_flags_macros.svh"

module alu_with_status_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] source_word, [31:16] dest_word
  input  logic [4:0]  in_tuser,   // [3:0] opcode, [4] byte_mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] result_word, [16] carry_flag,
                                  // [17] zero_flag, [18] negative_flag,
                                  // [19] overflow_flag, [23:20] zero
  output logic [0:0]  out_tuser   // [0] write_back
);

  logic                            s1_valid_r;
  logic [awsf_pkg::OpW-1:0]        s1_op_r;
  logic [awsf_pkg::DataW-1:0]      s1_src_r;
  logic [awsf_pkg::DataW-1:0]      s1_dst_r;
  logic                            s1_bm_r;
  logic                            s1_adv;
  logic                            in_fire;

  logic                            out_valid_r;
  logic [awsf_pkg::DataW-1:0]      out_res_r;
  logic                            out_wb_r;
  awsf_pkg::flags_t                out_flags_r;
  awsf_pkg::flags_t                status_r;

  logic [awsf_pkg::DataW-1:0]      res_nxt;
  logic                            wb_nxt;
  awsf_pkg::flags_t                flags_nxt;

  // operand stage moves on when the result register is free or being drained
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_tuser[3:0];
      s1_bm_r  <= in_tuser[4];
      s1_src_r <= in_tdata[15:0];
      s1_dst_r <= in_tdata[31:16];
    end
  end

  always_comb begin
    logic [awsf_pkg::DataW-1:0] a;
    logic [awsf_pkg::DataW-1:0] b;
    logic [awsf_pkg::DataW-1:0] mask;
    logic [awsf_pkg::DataW-1:0] add_b;
    logic [awsf_pkg::DataW-1:0] r;
    logic [awsf_pkg::DataW:0]   sum;
    logic [awsf_pkg::DataW-1:0] bcd;
    logic [4:0]                 ds;
    logic                       dc;
    logic                       dc_byte;
    logic                       add_cin;
    logic                       cin;
    logic                       sgn_a;
    logic                       sgn_b;
    logic                       sgn_r;
    awsf_pkg::flags_t           f;

    mask = s1_bm_r ? awsf_pkg::ByteMask : 16'hFFFF;
    a    = s1_dst_r & mask;
    b    = s1_src_r & mask;
    cin  = status_r.c;

    // shared adder for the add and subtract families
    if (s1_op_r inside {awsf_pkg::OP_SUB, awsf_pkg::OP_SUBC, awsf_pkg::OP_CMP}) begin
      add_b = ~s1_src_r & mask;
    end else begin
      add_b = b;
    end
    if (s1_op_r inside {awsf_pkg::OP_SUB, awsf_pkg::OP_CMP}) begin
      add_cin = 1'b1;
    end else if (s1_op_r == awsf_pkg::OP_ADD) begin
      add_cin = 1'b0;
    end else begin
      add_cin = cin;
    end
    sum = {1'b0, a} + {1'b0, add_b} + {16'd0, add_cin};

    // decimal adder, one digit per step
    bcd     = '0;
    dc      = cin;
    dc_byte = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ds = {1'b0, a[4*i +: 4]} + {1'b0, b[4*i +: 4]} + {4'd0, dc};
      if (ds > 5'd9) begin
        dc = 1'b1;
        ds = ds + 5'd6;
      end else begin
        dc = 1'b0;
      end
      bcd[4*i +: 4] = ds[3:0];
      if (i == 1) begin
        dc_byte = dc;
      end
    end

    f      = status_r;
    wb_nxt = 1'b1;
    r      = '0;
    sgn_r  = 1'b0;
    sgn_a  = s1_bm_r ? a[7] : a[15];
    sgn_b  = s1_bm_r ? add_b[7] : add_b[15];

    case (s1_op_r)
      awsf_pkg::OP_MOV: r = b;
      awsf_pkg::OP_ADD, awsf_pkg::OP_ADDC, awsf_pkg::OP_SUB,
      awsf_pkg::OP_SUBC, awsf_pkg::OP_CMP: begin
        r     = sum[15:0] & mask;
        sgn_r = s1_bm_r ? r[7] : r[15];
        f.c   = s1_bm_r ? sum[8] : sum[16];
        f.z   = (r == '0);
        f.n   = sgn_r;
        f.v   = (sgn_a ^ sgn_r) & (sgn_b ^ sgn_r);
        wb_nxt = (s1_op_r != awsf_pkg::OP_CMP);
      end
      awsf_pkg::OP_DADD: begin
        r   = bcd & mask;
        f.c = s1_bm_r ? dc_byte : dc;
        f.z = (r == '0);
        f.n = s1_bm_r ? r[7] : r[15];
        f.v = 1'b0;
      end
      awsf_pkg::OP_BIT, awsf_pkg::OP_AND: begin
        r   = a & b;
        f.z = (r == '0);
        f.c = (r != '0);
        f.n = s1_bm_r ? r[7] : r[15];
        f.v = 1'b0;
        wb_nxt = (s1_op_r != awsf_pkg::OP_BIT);
      end
      awsf_pkg::OP_BIC: r = a & ~b & mask;
      awsf_pkg::OP_BIS: r = a | b;
      awsf_pkg::OP_XOR: begin
        r   = a ^ b;
        f.z = (r == '0);
        f.c = (r != '0);
        f.n = s1_bm_r ? r[7] : r[15];
        f.v = s1_bm_r ? (a[7] & b[7]) : (a[15] & b[15]);
      end
      awsf_pkg::OP_RRC, awsf_pkg::OP_RRA: begin
        // sign position gets old carry (rrc) or keeps the old sign (rra)
        sgn_r = (s1_op_r == awsf_pkg::OP_RRC) ? cin : sgn_a;
        r     = a >> 1;
        if (s1_bm_r) begin
          r[7] = sgn_r;
        end else begin
          r[15] = sgn_r;
        end
        f.c = a[0];
        f.z = (r == '0);
        f.n = sgn_r;
        f.v = 1'b0;
      end
      awsf_pkg::OP_SWPB: r = {s1_dst_r[7:0], s1_dst_r[15:8]};
      awsf_pkg::OP_SXT: begin
        // always full word: bit 7 fills the whole upper byte
        r   = {{8{s1_dst_r[7]}}, s1_dst_r[7:0]};
        f.z = (r == '0);
        f.c = (r != '0);
        f.n = r[15];
        f.v = 1'b0;
      end
      default: r = b;
    endcase

    res_nxt   = r;
    flags_nxt = f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r    <= '0;
    end else begin
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        status_r    <= flags_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r   <= res_nxt;
      out_wb_r    <= wb_nxt;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {4'd0, out_flags_r.v, out_flags_r.n, out_flags_r.z,
                         out_flags_r.c, out_res_r};
  assign out_tuser[0] = out_wb_r;

  `AWSF_ASSERT_IMPL(a_out_flags_match, out_valid_r, out_flags_r == status_r, "result flags differ from stored flags")
  `AWSF_ASSERT_NEXT(a_flags_hold_idle, !s1_adv, $stable(status_r), "flags changed without a word")
  `AWSF_ASSERT_NEXT(a_wb_set, s1_adv && s1_op_r != awsf_pkg::OP_CMP && s1_op_r != awsf_pkg::OP_BIT, out_tuser[0], "write back missing")
  `AWSF_ASSERT_NEXT(a_swpb_keeps_flags, s1_adv && s1_op_r == awsf_pkg::OP_SWPB, $stable(status_r), "byte swap altered flags")

endmodule

// File: dv/tb_alu_with_status_flags.sv
module tb_alu_with_status_flags;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 2000;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [awsf_pkg::OpW-1:0]   op;
    logic [awsf_pkg::DataW-1:0] src;
    logic [awsf_pkg::DataW-1:0] dst;
    logic                       bm;
  } alu_op_t;

  typedef struct packed {
    logic [awsf_pkg::DataW-1:0] res;
    logic                       wb;
    awsf_pkg::flags_t           fl;
  } alu_res_t;

  localparam logic [awsf_pkg::DataW-1:0] CornerVals [8] = '{
    16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h00FF, 16'h0080, 16'h007F, 16'hFF00
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [4:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;

  alu_op_t          op_queue [$];
  alu_res_t         alu_expected [$];
  alu_op_t          op_on_bus;
  awsf_pkg::flags_t status_q = '0;
  int               err_cnt = 0;
  int               recv_cnt = 0;
  int               in_gap = 0;
  bit               in_idle = 1'b1;
  int               out_stall = 0;
  bit               out_idle = 1'b1;
  int               hold_left = 0;
  int               hold_seen = 0;
  logic             hold_off = 1'b0;
  int               quiet_cycles = 0;

  alu_with_status_flags dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // computes the result word and advances the stored flags
  function automatic alu_res_t alu_exec(alu_op_t w);
    alu_res_t                   o;
    logic [awsf_pkg::DataW-1:0] mask, msb, a, b, bb, r;
    logic [awsf_pkg::DataW:0]   sum;
    logic [4:0]                 ds;
    logic                       ci;
    int                         ndig;
    awsf_pkg::flags_t           f;
    mask = w.bm ? awsf_pkg::ByteMask : 16'hFFFF;
    msb = w.bm ? 16'h0080 : 16'h8000;
    a = w.dst & mask;
    b = w.src & mask;
    f = status_q;
    r = '0;
    o.wb = 1'b1;
    case (w.op)
      awsf_pkg::OP_MOV: begin
        r = b;
      end
      awsf_pkg::OP_ADD, awsf_pkg::OP_ADDC, awsf_pkg::OP_SUB, awsf_pkg::OP_SUBC,
      awsf_pkg::OP_CMP: begin
        bb = (w.op == awsf_pkg::OP_ADD || w.op == awsf_pkg::OP_ADDC) ? b
                                                                   : (~w.src & mask);
        if (w.op == awsf_pkg::OP_ADD) ci = 1'b0;
        else if (w.op == awsf_pkg::OP_ADDC || w.op == awsf_pkg::OP_SUBC) ci = status_q.c;
        else ci = 1'b1;
        sum = {1'b0, a} + {1'b0, bb} + ci;
        r = sum[awsf_pkg::DataW-1:0] & mask;
        f.c = sum > {1'b0, mask};
        f.v = ((a ^ r) & (bb ^ r) & msb) != 0;
        f.z = r == 0;
        f.n = (r & msb) != 0;
        o.wb = w.op != awsf_pkg::OP_CMP;
      end
      awsf_pkg::OP_DADD: begin
        ndig = w.bm ? 2 : 4;
        ci = status_q.c;
        for (int i = 0; i < 4; i++) begin
          if (i < ndig) begin
            ds = a[4*i +: 4] + b[4*i +: 4] + ci;
            if (ds > 9) begin
              ci = 1'b1;
              ds = ds + 5'd6;
            end else begin
              ci = 1'b0;
            end
            r[4*i +: 4] = ds[3:0];
          end
        end
        r = r & mask;
        f.c = ci;
        f.z = r == 0;
        f.n = (r & msb) != 0;
        f.v = 1'b0;
      end
      awsf_pkg::OP_BIT, awsf_pkg::OP_AND, awsf_pkg::OP_XOR: begin
        r = (w.op == awsf_pkg::OP_XOR) ? (a ^ b) : (a & b);
        f.z = r == 0;
        f.n = (r & msb) != 0;
        f.c = r != 0;
        f.v = (w.op == awsf_pkg::OP_XOR) && ((a & b & msb) != 0);
        o.wb = w.op != awsf_pkg::OP_BIT;
      end
      awsf_pkg::OP_BIC: begin
        r = a & ~b & mask;
      end
      awsf_pkg::OP_BIS: begin
        r = (a | b) & mask;
      end
      awsf_pkg::OP_RRC, awsf_pkg::OP_RRA: begin
        if (w.op == awsf_pkg::OP_RRC) r = ((status_q.c ? msb : 16'h0) | (a >> 1)) & mask;
        else r = ((a & msb) | (a >> 1)) & mask;
        f.c = a[0];
        f.z = r == 0;
        f.n = (r & msb) != 0;
        f.v = 1'b0;
      end
      awsf_pkg::OP_SWPB: begin
        r = {w.dst[7:0], w.dst[15:8]};
      end
      default: begin
        // sign extend always works on the full word
        r = {{8{w.dst[7]}}, w.dst[7:0]};
        f.z = r == 0;
        f.n = r[15];
        f.c = r != 0;
        f.v = 1'b0;
      end
    endcase
    status_q = f;
    o.res = r;
    o.fl = f;
    return o;
  endfunction

  function automatic logic [awsf_pkg::DataW-1:0] pick_operand(bit bcd);
    logic [awsf_pkg::DataW-1:0] v;
    int                         sel;
    sel = $urandom_range(0, 7);
    v = 16'($urandom);
    if (bcd && sel < 5) begin
      for (int i = 0; i < 4; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    end else if (sel < 2) begin
      v = CornerVals[$urandom_range(0, 7)];
    end
    return v;
  endfunction

  task automatic push_op(logic [awsf_pkg::OpW-1:0] op, logic [awsf_pkg::DataW-1:0] src,
                         logic [awsf_pkg::DataW-1:0] dst, logic bm);
    alu_op_t w;
    w.op = op;
    w.src = src;
    w.dst = dst;
    w.bm = bm;
    op_queue.push_back(w);
  endtask

  // driver: one word per handshake, random gaps in bursts
  always @(posedge clk) begin
    alu_op_t w;
    logic    fire;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        alu_expected.push_back(alu_exec(op_on_bus));
        if ($urandom_range(0, 49) == 0) in_idle = !in_idle;
        in_gap = in_idle ? $urandom_range(0, 15) : 0;
      end
      if (!in_tvalid || fire) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          w = op_queue.pop_front();
          op_on_bus = w;
          in_tvalid <= 1'b1;
          in_tdata <= {w.dst, w.src};
          in_tuser <= {w.bm, w.op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    alu_res_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        recv_cnt++;
        if (alu_expected.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("unexpected result word: tdata=%h tuser=%b", out_tdata, out_tuser);
        end else begin
          e = alu_expected.pop_front();
          if (out_tdata[15:0] !== e.res || out_tuser[0] !== e.wb ||
              out_tdata[16] !== e.fl.c || out_tdata[17] !== e.fl.z ||
              out_tdata[18] !== e.fl.n || out_tdata[19] !== e.fl.v ||
              out_tdata[23:20] !== 4'b0) begin
            err_cnt++;
            if (err_cnt <= MaxReports)
              $display({"mismatch: exp res=%h wb=%b cznv=%b%b%b%b",
                        "  got res=%h wb=%b cznv=%b%b%b%b pad=%h"},
                       e.res, e.wb, e.fl.c, e.fl.z, e.fl.n, e.fl.v,
                       out_tdata[15:0], out_tuser[0], out_tdata[16], out_tdata[17],
                       out_tdata[18], out_tdata[19], out_tdata[23:20]);
          end
        end
        if ($urandom_range(0, 49) == 0) out_idle = !out_idle;
        out_stall = out_idle ? $urandom_range(0, 15) : 0;
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off twice in the run so the pipeline backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        hold_seen++;
        if (hold_seen == 300 || hold_seen == 1200) hold_left = HoldCycles;
      end
      if (hold_left > 0) hold_left--;
      hold_off <= hold_left > 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_alu_with_status_flags NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [awsf_pkg::OpW-1:0] op;
    int                       total_items;
    // directed corners: carries, overflow, borrow chains, bcd wrap, byte ops
    push_op(awsf_pkg::OP_MOV,  16'hFFFF, 16'h0000, 1'b0);
    push_op(awsf_pkg::OP_MOV,  16'h1234, 16'hFFFF, 1'b1);
    push_op(awsf_pkg::OP_ADD,  16'h0001, 16'hFFFF, 1'b0);
    push_op(awsf_pkg::OP_ADDC, 16'h0000, 16'h0000, 1'b0);
    push_op(awsf_pkg::OP_ADD,  16'h0001, 16'h7FFF, 1'b0);
    push_op(awsf_pkg::OP_ADD,  16'h3401, 16'h12FF, 1'b1);
    push_op(awsf_pkg::OP_SUB,  16'h5555, 16'h5555, 1'b0);
    push_op(awsf_pkg::OP_SUBC, 16'h0001, 16'h0000, 1'b0);
    push_op(awsf_pkg::OP_SUBC, 16'h0000, 16'h0000, 1'b0);
    push_op(awsf_pkg::OP_CMP,  16'h0080, 16'h007F, 1'b1);
    push_op(awsf_pkg::OP_CMP,  16'h8000, 16'h7FFF, 1'b0);
    push_op(awsf_pkg::OP_DADD, 16'h0001, 16'h0099, 1'b1);
    push_op(awsf_pkg::OP_DADD, 16'h0000, 16'h9999, 1'b0);
    push_op(awsf_pkg::OP_DADD, 16'hFFFF, 16'hFFFF, 1'b0);
    push_op(awsf_pkg::OP_BIT,  16'h00F0, 16'h000F, 1'b0);
    push_op(awsf_pkg::OP_BIT,  16'h8000, 16'hFFFF, 1'b1);
    push_op(awsf_pkg::OP_BIC,  16'h00FF, 16'hFFFF, 1'b0);
    push_op(awsf_pkg::OP_BIS,  16'h8001, 16'h0000, 1'b1);
    push_op(awsf_pkg::OP_XOR,  16'h8000, 16'h8000, 1'b0);
    push_op(awsf_pkg::OP_AND,  16'hFFFF, 16'hFFFF, 1'b0);
    push_op(awsf_pkg::OP_RRC,  16'h0000, 16'h0001, 1'b0);
    push_op(awsf_pkg::OP_RRA,  16'h0000, 16'h0081, 1'b1);
    push_op(awsf_pkg::OP_SWPB, 16'h0000, 16'h12AB, 1'b1);
    push_op(awsf_pkg::OP_SXT,  16'h0000, 16'hFF80, 1'b1);
    push_op(awsf_pkg::OP_SXT,  16'h0000, 16'hFF7F, 1'b0);
    for (int i = 0; i < NumRandom; i++) begin
      op = 4'($urandom_range(0, 15));
      push_op(op, pick_operand(op == awsf_pkg::OP_DADD),
              pick_operand(op == awsf_pkg::OP_DADD), 1'($urandom_range(0, 1)));
    end
    total_items = op_queue.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // the watchdog ends the run if results stop coming
    while (recv_cnt < total_items) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && alu_expected.size() == 0 && recv_cnt == total_items) begin
      $display("tb_alu_with_status_flags OK");
    end else begin
      $display("tb_alu_with_status_flags NOT OK");
    end
    $finish;
  end

endmodule
